// File: src/hsv2rgb_pkg.sv
// Shared widths, constants and a helper function for the HSV to RGB converter.
package hsv2rgb_pkg;

  // Field widths of the pixel items.
  localparam int HUE_W   = 16;
  localparam int LEVEL_W = 8;

  // Hue times six: three sector bits above the sixteen fraction bits.
  localparam int SECT_W  = 3;
  localparam int HUE6_W  = HUE_W + SECT_W;

  // Full-scale level and the number of hue sectors.
  localparam int FULL_LEVEL = 255;
  localparam int SECTORS    = 6;

  // Scaled denominator 255 * 2^16 and the width that holds it.
  localparam int SCALE_W = LEVEL_W + HUE_W;
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(FULL_LEVEL * (2 ** HUE_W));

  // Width of a level times a scaled term.
  localparam int PROD_W = LEVEL_W + SCALE_W;

  // Hue sector codes, named by the hue range they cover.
  localparam logic [SECT_W-1:0] SECT_RED_YELLOW    = 3'd0;
  localparam logic [SECT_W-1:0] SECT_YELLOW_GREEN  = 3'd1;
  localparam logic [SECT_W-1:0] SECT_GREEN_CYAN    = 3'd2;
  localparam logic [SECT_W-1:0] SECT_CYAN_BLUE     = 3'd3;
  localparam logic [SECT_W-1:0] SECT_BLUE_MAGENTA  = 3'd4;

  // Floor of m / 255 for any m up to 255 * 255, by the add-and-shift identity.
  function automatic logic [LEVEL_W-1:0] div255(input logic [2*LEVEL_W-1:0] m);
    logic [2*LEVEL_W:0] sum;
    sum = {1'b0, m} + (2*LEVEL_W+1)'(m[2*LEVEL_W-1:LEVEL_W]) + (2*LEVEL_W+1)'(1);
    return sum[2*LEVEL_W-1:LEVEL_W];
  endfunction

endpackage

// File: src/hsv2rgb_if.sv
// Valid/ready channel interfaces for the HSV pixel input and the RGB pixel output.
interface hsv2rgb_hsv_if
  import hsv2rgb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [HUE_W-1:0]   hue;
  logic [LEVEL_W-1:0] saturation;
  logic [LEVEL_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsv2rgb_rgb_if
  import hsv2rgb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] red;
  logic [LEVEL_W-1:0] green;
  logic [LEVEL_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: src/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter: a four-stage pipeline from hue/saturation/value to RGB.
// Each accepted item is registered in stages 1, 2 and 3 and then in the output register,
// where its result is shown until it is taken.
// Throughput: one item per cycle; the whole pipeline advances together and holds
// while the output register is full and not taken.
// Reset (synchronous, active high) clears the stage valid bits; data regs are not reset.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  hsv2rgb_hsv_if.sink   hsv,
  hsv2rgb_rgb_if.source rgb
);

  // The pipeline moves when the output register is empty or is being taken.
  logic advance;
  assign advance   = !rgb.valid || rgb.ready;
  assign hsv.ready = advance;

  // Stage 1: hue times six, inputs carried along.
  logic               s1_valid;
  logic [HUE6_W-1:0]  s1_hue6;
  logic [LEVEL_W-1:0] s1_sat;
  logic [LEVEL_W-1:0] s1_bri;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= hsv.valid;
    end
    if (advance) begin
      s1_hue6 <= HUE6_W'(hsv.hue) * HUE6_W'(SECTORS);
      s1_sat  <= hsv.saturation;
      s1_bri  <= hsv.brightness;
    end
  end

  // Stage 2: saturation times fraction, forming the three scaled factors.
  logic [SCALE_W-1:0] sat_frac;
  logic [LEVEL_W-1:0] sat_inv;
  assign sat_frac = SCALE_W'(s1_sat) * SCALE_W'(s1_hue6[HUE_W-1:0]);
  assign sat_inv  = LEVEL_W'(FULL_LEVEL) - s1_sat;

  logic               s2_valid;
  logic [SECT_W-1:0]  s2_sect;
  logic [LEVEL_W-1:0] s2_bri;
  logic [LEVEL_W-1:0] s2_fp;
  logic [SCALE_W-1:0] s2_fq;
  logic [SCALE_W-1:0] s2_ft;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
    if (advance) begin
      s2_sect <= s1_hue6[HUE6_W-1:HUE_W];
      s2_bri  <= s1_bri;
      s2_fp   <= sat_inv;
      s2_fq   <= SCALE_ONE - sat_frac;
      s2_ft   <= {sat_inv, {HUE_W{1'b0}}} + sat_frac;
    end
  end

  // Stage 3: brightness times each factor, dropping the sixteen fraction bits.
  logic [PROD_W-1:0]    prod_q;
  logic [PROD_W-1:0]    prod_t;
  logic [2*LEVEL_W-1:0] prod_p;
  assign prod_q = PROD_W'(s2_bri) * PROD_W'(s2_fq);
  assign prod_t = PROD_W'(s2_bri) * PROD_W'(s2_ft);
  assign prod_p = (2*LEVEL_W)'(s2_bri) * (2*LEVEL_W)'(s2_fp);

  logic                 s3_valid;
  logic [SECT_W-1:0]    s3_sect;
  logic [LEVEL_W-1:0]   s3_bri;
  logic [2*LEVEL_W-1:0] s3_mp;
  logic [2*LEVEL_W-1:0] s3_mq;
  logic [2*LEVEL_W-1:0] s3_mt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
    if (advance) begin
      s3_sect <= s2_sect;
      s3_bri  <= s2_bri;
      s3_mp   <= prod_p;
      s3_mq   <= prod_q[PROD_W-1:HUE_W];
      s3_mt   <= prod_t[PROD_W-1:HUE_W];
    end
  end

  // Stage 4: divide by 255 and route the levels to channels by sector.
  logic [LEVEL_W-1:0] lvl_p;
  logic [LEVEL_W-1:0] lvl_q;
  logic [LEVEL_W-1:0] lvl_t;
  logic [LEVEL_W-1:0] red_next;
  logic [LEVEL_W-1:0] green_next;
  logic [LEVEL_W-1:0] blue_next;

  assign lvl_p = div255(s3_mp);
  assign lvl_q = div255(s3_mq);
  assign lvl_t = div255(s3_mt);

  always_comb begin
    unique case (s3_sect)
      SECT_RED_YELLOW: begin
        red_next = s3_bri; green_next = lvl_t;  blue_next = lvl_p;
      end
      SECT_YELLOW_GREEN: begin
        red_next = lvl_q;  green_next = s3_bri; blue_next = lvl_p;
      end
      SECT_GREEN_CYAN: begin
        red_next = lvl_p;  green_next = s3_bri; blue_next = lvl_t;
      end
      SECT_CYAN_BLUE: begin
        red_next = lvl_p;  green_next = lvl_q;  blue_next = s3_bri;
      end
      SECT_BLUE_MAGENTA: begin
        red_next = lvl_t;  green_next = lvl_p;  blue_next = s3_bri;
      end
      default: begin
        red_next = s3_bri; green_next = lvl_p;  blue_next = lvl_q;
      end
    endcase
  end

  // Output register, held while the result is not taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rgb.valid <= 1'b0;
    end else if (advance) begin
      rgb.valid <= s3_valid;
    end
    if (advance) begin
      rgb.red   <= red_next;
      rgb.green <= green_next;
      rgb.blue  <= blue_next;
    end
  end

endmodule

// File: src/hsv2rgb_checker.sv
// Port-level assertions for the HSV to RGB converter, bound to its top level.
module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               hsv_valid,
  input logic               hsv_ready,
  input logic [LEVEL_W-1:0] hsv_saturation,
  input logic [LEVEL_W-1:0] hsv_brightness,
  input logic               rgb_valid,
  input logic               rgb_ready,
  input logic [LEVEL_W-1:0] rgb_red,
  input logic [LEVEL_W-1:0] rgb_green,
  input logic [LEVEL_W-1:0] rgb_blue
);

  // A result that is not taken stays in place unchanged.
  assert property (@(posedge clk) disable iff (rst)
    rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb_red) && $stable(rgb_green)
      && $stable(rgb_blue))
    else $error("stalled result changed");

  // Reset empties the pipeline.
  assert property (@(posedge clk) $past(rst) |-> !rgb_valid)
    else $error("result shown right after reset");

  // The converter takes items whenever its output register is free.
  assert property (@(posedge clk) disable iff (rst) !rgb_valid |-> hsv_ready)
    else $error("input blocked with empty output");

  // With the output drained, an item with zero saturation comes out as grey.
  assert property (@(posedge clk) disable iff (rst)
    (hsv_valid && hsv_ready && hsv_saturation == '0) ##1 rgb_ready ##1 rgb_ready
      ##1 rgb_ready
    |=> rgb_valid && rgb_red == $past(hsv_brightness, 4)
      && rgb_green == $past(hsv_brightness, 4) && rgb_blue == $past(hsv_brightness, 4))
    else $error("grey item not delivered on time");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk            (clk),
  .rst            (rst),
  .hsv_valid      (hsv.valid),
  .hsv_ready      (hsv.ready),
  .hsv_saturation (hsv.saturation),
  .hsv_brightness (hsv.brightness),
  .rgb_valid      (rgb.valid),
  .rgb_ready      (rgb.ready),
  .rgb_red        (rgb.red),
  .rgb_green      (rgb.green),
  .rgb_blue       (rgb.blue)
);
